// ===== sv/twe_pkg.sv =====
// Shared types and constants for the tick wrap extender.
// No dependencies; every other file refers to it by scoped names.
package twe_pkg;

	localparam int unsigned TICK_W = 32;
	localparam int unsigned FULL_W = 64;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [TICK_W-1:0] HALF_RANGE_DEF = 32'h8000_0000;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_STARTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BACK_FAR    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FWD_FAR     = 2'd3;

	// register indexes (paddr[2])
	localparam logic REG_MAX_BACKWARD = 1'b0;
	localparam logic REG_START_TICK   = 1'b1;

	typedef struct packed {
		logic [TICK_W-1:0] max_backward;
		logic              start_wr;
		logic [TICK_W-1:0] start_tick;
	} cfg_t;

endpackage

// ===== sv/twe_if.sv =====
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on twe_pkg for field widths.
interface twe_tick_if;
	logic                         valid;
	logic                         ready;
	logic [twe_pkg::TICK_W-1:0]   tick_low;

	modport source (output valid, output tick_low, input ready);
	modport sink (input valid, input tick_low, output ready);
endinterface

interface twe_result_if;
	logic                         valid;
	logic                         ready;
	logic [twe_pkg::STATUS_W-1:0] status;
	logic [twe_pkg::FULL_W-1:0]   tick_full;
	logic [twe_pkg::TICK_W-1:0]   wraps;
	logic [twe_pkg::TICK_W-1:0]   rejects;

	modport source (output valid, output status, output tick_full, output wraps,
		output rejects, input ready);
	modport sink (input valid, input status, input tick_full, input wraps,
		input rejects, output ready);
endinterface

// ===== sv/twe_regs.sv =====
// APB-style register block: max_backward and start_tick.
// Depends on twe_pkg; hands the values and the restart strobe on as a cfg_t.
module twe_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [twe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [twe_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [twe_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output twe_pkg::cfg_t                    cfg
);

	logic [twe_pkg::TICK_W-1:0] max_backward_q;
	logic [twe_pkg::TICK_W-1:0] start_tick_q;
	logic                       wr_en;
	logic                       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_backward_q <= '0;
			start_tick_q   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				twe_pkg::REG_MAX_BACKWARD: max_backward_q <= pwdata[twe_pkg::TICK_W-1:0];
				twe_pkg::REG_START_TICK:   start_tick_q   <= pwdata[twe_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			twe_pkg::REG_MAX_BACKWARD: prdata = max_backward_q;
			twe_pkg::REG_START_TICK:   prdata = start_tick_q;
			default:                   prdata = '0;
		endcase
	end

	assign cfg.max_backward = max_backward_q;
	assign cfg.start_wr     = wr_en & (reg_idx == twe_pkg::REG_START_TICK);
	assign cfg.start_tick   = pwdata[twe_pkg::TICK_W-1:0];

endmodule

// ===== sv/twe_track.sv =====
// Tracking state, the compare-and-update logic and the result register.
// Depends on twe_pkg and the channel interfaces in twe_if.sv.
module twe_track #(
	parameter logic [twe_pkg::TICK_W-1:0] HALF_RANGE = twe_pkg::HALF_RANGE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  twe_pkg::cfg_t    cfg,
	twe_tick_if.sink         tick_in,
	twe_result_if.source     result
);

	logic                         started_q;
	logic [twe_pkg::TICK_W-1:0]   last_low_q;
	logic [twe_pkg::TICK_W-1:0]   high_word_q;
	logic [twe_pkg::TICK_W-1:0]   wrap_total_q;
	logic [twe_pkg::TICK_W-1:0]   reject_total_q;

	logic                         out_valid_q;
	logic [twe_pkg::STATUS_W-1:0] status_q;
	logic [twe_pkg::FULL_W-1:0]   tick_full_q;
	logic [twe_pkg::TICK_W-1:0]   wraps_q;
	logic [twe_pkg::TICK_W-1:0]   rejects_q;

	logic                         fire;
	logic [twe_pkg::TICK_W-1:0]   tick;
	logic [twe_pkg::TICK_W-1:0]   back;
	logic [twe_pkg::TICK_W-1:0]   fwd;
	logic                         is_back;
	logic                         is_wrap;
	logic                         back_far;
	logic                         fwd_far;
	logic                         take;
	logic [twe_pkg::STATUS_W-1:0] status_d;
	logic [twe_pkg::TICK_W-1:0]   high_word_d;
	logic [twe_pkg::TICK_W-1:0]   wrap_total_d;
	logic [twe_pkg::TICK_W-1:0]   reject_total_d;

	// accept while the result register is empty or draining this cycle
	assign tick_in.ready = ~out_valid_q | result.ready;
	assign fire          = tick_in.valid & tick_in.ready;
	assign tick          = tick_in.tick_low;

	assign is_back  = tick < last_low_q;
	assign back     = last_low_q - tick;
	assign fwd      = tick - last_low_q;
	assign is_wrap  = started_q & is_back & (back > HALF_RANGE);
	assign back_far = started_q & is_back & ~is_wrap & (back > cfg.max_backward);
	assign fwd_far  = started_q & ~is_back & (fwd > HALF_RANGE);

	always_comb begin
		if (!started_q)
			status_d = twe_pkg::ST_NOT_STARTED;
		else if (back_far)
			status_d = twe_pkg::ST_BACK_FAR;
		else if (fwd_far)
			status_d = twe_pkg::ST_FWD_FAR;
		else
			status_d = twe_pkg::ST_OK;
	end

	assign take           = status_d == twe_pkg::ST_OK;
	assign high_word_d    = high_word_q + {{(twe_pkg::TICK_W-1){1'b0}}, is_wrap};
	assign wrap_total_d   = wrap_total_q + {{(twe_pkg::TICK_W-1){1'b0}}, is_wrap};
	assign reject_total_d = reject_total_q
		+ {{(twe_pkg::TICK_W-1){1'b0}}, back_far | fwd_far};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q      <= 1'b0;
			last_low_q     <= '0;
			high_word_q    <= '0;
			wrap_total_q   <= '0;
			reject_total_q <= '0;
		end else if (cfg.start_wr) begin
			// restart tracking from the written tick
			started_q      <= 1'b1;
			last_low_q     <= cfg.start_tick;
			high_word_q    <= '0;
			wrap_total_q   <= '0;
			reject_total_q <= '0;
		end else if (fire) begin
			high_word_q    <= high_word_d;
			wrap_total_q   <= wrap_total_d;
			reject_total_q <= reject_total_d;
			if (take)
				last_low_q <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			tick_full_q <= take ? {high_word_d, tick} : '0;
			wraps_q     <= wrap_total_d;
			rejects_q   <= reject_total_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = status_q;
	assign result.tick_full = tick_full_q;
	assign result.wraps     = wraps_q;
	assign result.rejects   = rejects_q;

endmodule

// ===== sv/tick_wrap_extender_core.sv =====
// Tick wrap extender: takes one raw 32-bit tick per word and returns its 64-bit
// extension with a status code and the running wrap and reject counts. The
// compare against the last tick and the counter update fit in one pass between the
// input and the result register, so a new word is taken every cycle unless a
// stalled result blocks the input, and its result appears in the next cycle. Words
// arriving before start_tick is first written come back as not started.
// Depends on twe_pkg, twe_if.sv, twe_regs and twe_track.
module tick_wrap_extender_core #(
	parameter logic [twe_pkg::TICK_W-1:0] HALF_RANGE = twe_pkg::HALF_RANGE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [twe_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [twe_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [twe_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	twe_tick_if.sink                         tick_in,
	twe_result_if.source                     result
);

	twe_pkg::cfg_t cfg;

	twe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	twe_track #(
		.HALF_RANGE (HALF_RANGE)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick_in (tick_in),
		.result  (result)
	);

`ifndef SYNTHESIS
	// a rejected or early word never carries an extended tick
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status != twe_pkg::ST_OK) |-> result.tick_full == '0)
		else $error("rejected word with nonzero tick_full");

	// a stalled full result register blocks the input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !tick_in.ready)
		else $error("input taken while result stalled");

	// every accepted word yields a result in the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		tick_in.valid && tick_in.ready |=> result.valid)
		else $error("accepted word gave no result");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for tick_wrap_extender_core: directed table, then random ticks checked
// against an in-bench tick extension predictor. Depends on twe_pkg and twe_if.sv.
`timescale 1ns / 100ps

module tb;

	localparam logic [twe_pkg::TICK_W-1:0] HALF_SPAN = twe_pkg::HALF_RANGE_DEF;
	localparam int unsigned HOLD_CYC = 300;
	localparam int unsigned SETTLE_CYC = 4;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 240;

	typedef struct packed {
		logic [twe_pkg::STATUS_W-1:0] status;
		logic [twe_pkg::FULL_W-1:0]   tick_full;
		logic [twe_pkg::TICK_W-1:0]   wraps;
		logic [twe_pkg::TICK_W-1:0]   rejects;
	} tick_res_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_MAXB, ROW_START} row_kind_t;

	typedef struct packed {
		row_kind_t                    kind;
		logic [twe_pkg::TICK_W-1:0]   value;
		logic                         chk;
		logic [twe_pkg::STATUS_W-1:0] status;
		logic [twe_pkg::FULL_W-1:0]   tick_full;
		logic [twe_pkg::TICK_W-1:0]   wraps;
		logic [twe_pkg::TICK_W-1:0]   rejects;
	} row_t;

	localparam int unsigned DIR_N = 28;
	localparam row_t DIR_ROWS [DIR_N] = '{
		'{ROW_TICK,  32'h0000_0000, 1'b1, twe_pkg::ST_NOT_STARTED, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'hFFFF_FFFF, 1'b1, twe_pkg::ST_NOT_STARTED, 64'h0, 32'd0, 32'd0},
		'{ROW_MAXB,  32'h0000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0005, 1'b1, twe_pkg::ST_NOT_STARTED, 64'h0, 32'd0, 32'd0},
		'{ROW_START, 32'h0000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0000, 1'b1, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h8000_0000, 1'b1, twe_pkg::ST_OK, 64'h0000_0000_8000_0000,
			32'd0, 32'd0},
		'{ROW_TICK,  32'hFFFF_FFFF, 1'b1, twe_pkg::ST_OK, 64'h0000_0000_FFFF_FFFF,
			32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0000, 1'b1, twe_pkg::ST_OK, 64'h0000_0001_0000_0000,
			32'd1, 32'd0},
		'{ROW_TICK,  32'h8000_0001, 1'b1, twe_pkg::ST_FWD_FAR, 64'h0, 32'd1, 32'd1},
		'{ROW_TICK,  32'h0000_0064, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0063, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_MAXB,  32'hFFFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0032, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h4000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h8000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'hFFFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_MAXB,  32'h7FFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h8000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_START, 32'hFFFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h0000_0000, 1'b1, twe_pkg::ST_OK, 64'h0000_0001_0000_0000,
			32'd1, 32'd0},
		'{ROW_TICK,  32'hFFFF_FFFF, 1'b1, twe_pkg::ST_FWD_FAR, 64'h0, 32'd1, 32'd1},
		'{ROW_MAXB,  32'h8000_0000, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h7FFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'hFFFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0},
		'{ROW_TICK,  32'h7FFF_FFFF, 1'b0, twe_pkg::ST_OK, 64'h0, 32'd0, 32'd0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [twe_pkg::APB_ADDR_W-1:0] paddr;
	logic [twe_pkg::APB_DATA_W-1:0] pwdata;
	logic [twe_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	twe_tick_if tick_ch ();
	twe_result_if res_ch ();

	tick_wrap_extender_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tick_in (tick_ch),
		.result  (res_ch)
	);

	// tracker copy
	logic                       trk_started;
	logic [twe_pkg::TICK_W-1:0] trk_last;
	logic [twe_pkg::TICK_W-1:0] trk_high;
	logic [twe_pkg::TICK_W-1:0] trk_wraps;
	logic [twe_pkg::TICK_W-1:0] trk_rejects;
	logic [twe_pkg::TICK_W-1:0] lim_back;

	tick_res_t pending_results[$];
	int unsigned err_cnt;
	bit hold_rx;
	bit rx_steady;

	function automatic tick_res_t extend_tick(input logic [twe_pkg::TICK_W-1:0] t);
		tick_res_t r;
		logic [twe_pkg::TICK_W-1:0] step;
		r.status = twe_pkg::ST_OK;
		r.tick_full = '0;
		if (!trk_started) begin
			r.status = twe_pkg::ST_NOT_STARTED;
		end else if (t < trk_last) begin
			step = trk_last - t;
			if (step > HALF_SPAN) begin
				trk_high = trk_high + 32'd1;
				trk_wraps = trk_wraps + 32'd1;
			end else if (step > lim_back) begin
				trk_rejects = trk_rejects + 32'd1;
				r.status = twe_pkg::ST_BACK_FAR;
			end
		end else begin
			step = t - trk_last;
			if (step > HALF_SPAN) begin
				trk_rejects = trk_rejects + 32'd1;
				r.status = twe_pkg::ST_FWD_FAR;
			end
		end
		if (r.status == twe_pkg::ST_OK) begin
			trk_last = t;
			r.tick_full = {trk_high, t};
		end
		r.wraps = trk_wraps;
		r.rejects = trk_rejects;
		return r;
	endfunction

	function automatic void load_reg(input logic idx, input logic [twe_pkg::TICK_W-1:0] v);
		if (idx == twe_pkg::REG_MAX_BACKWARD) begin
			lim_back = v;
		end else begin
			trk_started = 1'b1;
			trk_last = v;
			trk_high = '0;
			trk_wraps = '0;
			trk_rejects = '0;
		end
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [twe_pkg::TICK_W-1:0] gen_tick();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return trk_last + $urandom_range(0, 255);
		else if (r < 55)
			return trk_last + $urandom_range(32'h1000_0000, HALF_SPAN);
		else if (r < 65)
			return trk_last + $urandom_range(0, HALF_SPAN);
		else if (r < 75)
			return trk_last - $urandom_range(0, 4095);
		else if (r < 80)
			return trk_last - lim_back - 32'd1 + $urandom_range(0, 2);
		else if (r < 85)
			return trk_last + HALF_SPAN + $urandom_range(0, 1);
		else if (r < 90)
			return trk_last - HALF_SPAN - $urandom_range(0, 1);
		return $urandom();
	endfunction

	// offer one word, wait for it to be taken, then idle for gap cycles
	task automatic send_tick(input logic [twe_pkg::TICK_W-1:0] t, input int unsigned gap,
			input logic chk, input tick_res_t typed);
		tick_res_t r;
		tick_ch.valid <= 1'b1;
		tick_ch.tick_low <= t;
		do @(posedge clk); while (!tick_ch.ready);
		r = extend_tick(t);
		pending_results.push_back(chk ? typed : r);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [twe_pkg::TICK_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		load_reg(idx, v);
		// read back right away
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== v) begin
			$error("prdata: expected %h, got %h", v, prdata);
			err_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// result side: random stalls, one long hold-off on request, steady ready when asked
	initial begin
		int unsigned stall;
		res_ch.ready = 1'b0;
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
			end else if (rx_steady) begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					res_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end else begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		tick_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending: status %0d tick_full %h",
					res_ch.status, res_ch.tick_full);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					err_cnt++;
				end
				if (res_ch.tick_full !== want.tick_full) begin
					$error("tick_full: expected %h, got %h", want.tick_full, res_ch.tick_full);
					err_cnt++;
				end
				if (res_ch.wraps !== want.wraps) begin
					$error("wraps: expected %0d, got %0d", want.wraps, res_ch.wraps);
					err_cnt++;
				end
				if (res_ch.rejects !== want.rejects) begin
					$error("rejects: expected %0d, got %0d", want.rejects, res_ch.rejects);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		tick_res_t typed;
		logic [twe_pkg::TICK_W-1:0] maxb_set [PHASES];
		logic [twe_pkg::TICK_W-1:0] start_set [PHASES];
		int unsigned gap;
		int unsigned burst;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.tick_low = '0;
		err_cnt = 0;
		hold_rx = 1'b0;
		rx_steady = 1'b0;
		trk_started = 1'b0;
		trk_last = '0;
		trk_high = '0;
		trk_wraps = '0;
		trk_rejects = '0;
		lim_back = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			case (DIR_ROWS[i].kind)
				ROW_TICK: begin
					typed = '{DIR_ROWS[i].status, DIR_ROWS[i].tick_full,
						DIR_ROWS[i].wraps, DIR_ROWS[i].rejects};
					send_tick(DIR_ROWS[i].value, pick_gap(), DIR_ROWS[i].chk, typed);
				end
				ROW_MAXB: begin
					settle();
					reg_write(twe_pkg::REG_MAX_BACKWARD, DIR_ROWS[i].value);
				end
				default: begin
					settle();
					reg_write(twe_pkg::REG_START_TICK, DIR_ROWS[i].value);
				end
			endcase
		end

		maxb_set = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1000, $urandom()};
		start_set = '{32'h0, 32'hFFFF_FFFF, $urandom(), 32'h8000_0000, 32'h0, $urandom()};
		burst = 0;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			reg_write(twe_pkg::REG_MAX_BACKWARD, maxb_set[p]);
			// phase four keeps tracking across the limit change
			if (p != 4)
				reg_write(twe_pkg::REG_START_TICK, start_set[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 20) begin
					hold_rx = 1'b1;
					burst = 40;
				end
				if (p == 3 && n == 120)
					settle();
				rx_steady = (n >= 180 && n < 220);
				if (burst > 0) begin
					burst--;
					gap = 0;
				end else if (rx_steady) begin
					gap = 0;
				end else begin
					gap = pick_gap();
				end
				send_tick(gen_tick(), gap, 1'b0, '0);
			end
			rx_steady = 1'b0;
		end

		settle();
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/twe_pkg.sv
sv/twe_if.sv
sv/twe_regs.sv
sv/twe_track.sv
sv/tick_wrap_extender_core.sv
tb/tb.sv
